// ===== design/stdf_pkg.sv =====
package stdf_pkg;

  localparam int SIEVE_LIMIT = 65536;
  localparam int PRIME_SLOTS = 8192;

  localparam int MAP_DEPTH = SIEVE_LIMIT + 1;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int SLOT_AW   = $clog2(PRIME_SLOTS);
  localparam int CNT_W     = $clog2(PRIME_SLOTS + 1);
  localparam int PRIME_W   = $clog2(SIEVE_LIMIT + 1);
  localparam int NUM_W     = 31;
  localparam int ROOT_W    = (NUM_W + 1) / 2;
  localparam int OUT_CNT_W = 14;

  typedef enum logic {
    ACT_BUILD  = 1'b0,
    ACT_FACTOR = 1'b1
  } action_t;

  typedef struct packed {
    logic [NUM_W-1:0]     factor;
    logic                 factor_valid;
    logic [OUT_CNT_W-1:0] prime_count;
    logic                 not_ready;
    logic                 last;
  } rsp_t;

  function automatic rsp_t make_rsp(logic [NUM_W-1:0] factor, logic factor_valid,
                                    logic [CNT_W-1:0] count, logic not_ready,
                                    logic last);
    rsp_t r;
    r.factor       = factor;
    r.factor_valid = factor_valid;
    r.prime_count  = OUT_CNT_W'(count);
    r.not_ready    = not_ready;
    r.last         = last;
    return r;
  endfunction

endpackage

// ===== design/stdf_req_if.sv =====
interface stdf_req_if import stdf_pkg::*;;
  logic             valid;
  logic             ready;
  action_t          action;
  logic [NUM_W-1:0] number;

  modport source (output valid, action, number, input ready);
  modport sink (input valid, action, number, output ready);
endinterface

// ===== design/stdf_rsp_if.sv =====
interface stdf_rsp_if import stdf_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [NUM_W-1:0]     factor;
  logic                 factor_valid;
  logic [OUT_CNT_W-1:0] prime_count;
  logic                 not_ready;
  logic                 last;

  modport source (output valid, factor, factor_valid, prime_count, not_ready, last,
                  input ready);
  modport sink (input valid, factor, factor_valid, prime_count, not_ready, last,
                output ready);
endinterface

// ===== design/sieve_trial_division_factorizer.sv =====
// Prime factorizer: a build transfer (action 0) clears the composite map in a pass over
// all SIEVE_LIMIT+1 entries, then runs a linear sieve over 2..SIEVE_LIMIT, storing up to
// PRIME_SLOTS primes, and answers with one result carrying the prime count. The marking
// cost is set by the serial divider that checks i mod p. A factor transfer (action 1)
// takes a square root, then trial-divides by stored primes up to the first one at or
// above the root, or the last stored one, again with the serial divider.
// Results come out in ascending factor order, the last marked by last; one item is
// worked on at a time and req.ready is high only while idle.
module sieve_trial_division_factorizer import stdf_pkg::*; (
  input logic        clk,
  input logic        rst,
  stdf_req_if.sink   req,
  stdf_rsp_if.source rsp
);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_SV_RDC, S_SV_CHK, S_SV_RDP, S_SV_MUL, S_SV_MARK, S_SV_DIV,
    S_SV_NEXT, S_BUILD_OUT, S_F_START, S_F_SQRT, S_F_RDP, S_F_LATP, S_F_DIVGO,
    S_F_DIV, S_F_EMITP, S_F_FIN1, S_F_FIN2
  } state_t;

  state_t state;

  // sieve and trial-division registers
  logic [MAP_AW-1:0]    clr_addr;
  logic [PRIME_W-1:0]   i;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     j;
  logic [PRIME_W-1:0]   p;
  logic [2*PRIME_W-1:0] prod;
  logic [NUM_W-1:0]     n;
  logic [ROOT_W-1:0]    root;
  logic [PRIME_W-1:0]   pend;
  logic                 pend_v;
  logic                 table_ready;

  // output register
  logic out_valid;
  rsp_t o;
  logic out_free;
  logic out_load;

  // memory ports
  logic               map_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic               map_wdata;
  logic               map_rd;
  logic               tab_we;
  logic [PRIME_W-1:0] tab_rd;

  // divider shared by sieve and trial division; square-root unit
  logic               div_start;
  logic [NUM_W-1:0]   div_dividend;
  logic               div_busy;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;
  logic [PRIME_W-1:0] div_rem;
  logic               sqrt_start;
  logic               sqrt_busy;
  logic               sqrt_done;
  logic [ROOT_W-1:0]  sqrt_root;

  logic prod_over;
  logic n_big;

  always_comb begin
    prod_over    = prod > (2 * PRIME_W)'(SIEVE_LIMIT);
    n_big        = n > NUM_W'(1);
    out_free     = !out_valid || rsp.ready;
    // states that put a result into the output register
    out_load     = out_free && ((state == S_BUILD_OUT) ||
                                (state == S_F_START && (!table_ready || !n_big)) ||
                                (state == S_F_EMITP) ||
                                (state == S_F_FIN1 && pend_v) ||
                                (state == S_F_FIN2));
    // clearing pass writes 1 only at entry one, marking writes 1 at i*p
    map_we       = (state == S_CLR) || (state == S_SV_MARK && !prod_over);
    map_waddr    = (state == S_CLR) ? clr_addr : prod[MAP_AW-1:0];
    map_wdata    = (state == S_CLR) ? (clr_addr == MAP_AW'(1)) : 1'b1;
    // a new prime is stored while the table has room
    tab_we       = (state == S_SV_CHK) && !map_rd && (cnt < CNT_W'(PRIME_SLOTS));
    div_start    = (state == S_SV_MARK && !prod_over) || (state == S_F_DIVGO);
    div_dividend = (state == S_F_DIVGO) ? n : NUM_W'(i);
    sqrt_start   = (state == S_F_START) && table_ready && n_big;
  end

  stdf_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (MAP_AW'(i)),
    .rdata (map_rd)
  );

  stdf_ram #(.WIDTH(PRIME_W), .DEPTH(PRIME_SLOTS)) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (cnt[SLOT_AW-1:0]),
    .wdata (i),
    .raddr (j[SLOT_AW-1:0]),
    .rdata (tab_rd)
  );

  stdf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (p),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  stdf_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .n     (n),
    .busy  (sqrt_busy),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      table_ready <= 1'b0;
      cnt         <= '0;
      pend_v      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            n <= req.number;
            if (req.action == ACT_BUILD) begin
              clr_addr <= '0;
              state    <= S_CLR;
            end else begin
              state <= S_F_START;
            end
          end
        end
        // composite map clearing pass
        S_CLR: begin
          clr_addr <= clr_addr + MAP_AW'(1);
          if (clr_addr == MAP_AW'(SIEVE_LIMIT)) begin
            cnt   <= '0;
            i     <= PRIME_W'(2);
            state <= S_SV_RDC;
          end
        end
        S_SV_RDC: state <= S_SV_CHK;
        S_SV_CHK: begin
          if (tab_we) begin
            cnt <= cnt + CNT_W'(1);
          end
          j     <= '0;
          state <= S_SV_RDP;
        end
        // walk stored primes, marking i*p until p divides i, i*p passes SIEVE_LIMIT or the primes run out
        S_SV_RDP: begin
          if (j < cnt) begin
            state <= S_SV_MUL;
          end else begin
            state <= S_SV_NEXT;
          end
        end
        S_SV_MUL: begin
          p     <= tab_rd;
          prod  <= {PRIME_W'(0), i} * {PRIME_W'(0), tab_rd};
          state <= S_SV_MARK;
        end
        S_SV_MARK: begin
          if (prod_over) begin
            state <= S_SV_NEXT;
          end else begin
            state <= S_SV_DIV;
          end
        end
        S_SV_DIV: begin
          if (div_done) begin
            if (div_rem == '0) begin
              state <= S_SV_NEXT;
            end else begin
              j     <= j + CNT_W'(1);
              state <= S_SV_RDP;
            end
          end
        end
        S_SV_NEXT: begin
          if (i == PRIME_W'(SIEVE_LIMIT)) begin
            state <= S_BUILD_OUT;
          end else begin
            i     <= i + PRIME_W'(1);
            state <= S_SV_RDC;
          end
        end
        S_BUILD_OUT: begin
          if (out_free) begin
            o           <= make_rsp('0, 1'b0, cnt, 1'b0, 1'b1);
            table_ready <= 1'b1;
            state       <= S_IDLE;
          end
        end
        // factor request: special answers or start the root
        S_F_START: begin
          pend_v <= 1'b0;
          if (!table_ready) begin
            if (out_free) begin
              o     <= make_rsp('0, 1'b0, '0, 1'b1, 1'b1);
              state <= S_IDLE;
            end
          end else if (!n_big) begin
            if (out_free) begin
              o     <= make_rsp('0, 1'b0, '0, 1'b0, 1'b1);
              state <= S_IDLE;
            end
          end else begin
            state <= S_F_SQRT;
          end
        end
        S_F_SQRT: begin
          if (sqrt_done) begin
            root  <= sqrt_root;
            j     <= '0;
            state <= S_F_RDP;
          end
        end
        S_F_RDP:  state <= S_F_LATP;
        S_F_LATP: begin
          p     <= tab_rd;
          state <= S_F_DIVGO;
        end
        S_F_DIVGO: state <= S_F_DIV;
        // a factor is held back one step so the final one can carry last
        S_F_DIV: begin
          if (div_done) begin
            if (div_rem == '0) begin
              if (pend_v) begin
                state <= S_F_EMITP;
              end else begin
                pend   <= p;
                pend_v <= 1'b1;
                n      <= div_quot;
                state  <= S_F_DIVGO;
              end
            end else if (p >= PRIME_W'(root) || (j + CNT_W'(1)) == cnt) begin
              state <= S_F_FIN1;
            end else begin
              j     <= j + CNT_W'(1);
              state <= S_F_RDP;
            end
          end
        end
        S_F_EMITP: begin
          if (out_free) begin
            o     <= make_rsp(NUM_W'(pend), 1'b1, '0, 1'b0, 1'b0);
            pend  <= p;
            n     <= div_quot;
            state <= S_F_DIVGO;
          end
        end
        S_F_FIN1: begin
          if (pend_v) begin
            if (out_free) begin
              o      <= make_rsp(NUM_W'(pend), 1'b1, '0, 1'b0, !n_big);
              pend_v <= 1'b0;
              state  <= n_big ? S_F_FIN2 : S_IDLE;
            end
          end else begin
            state <= S_F_FIN2;
          end
        end
        // leftover above one, or an empty result
        S_F_FIN2: begin
          if (out_free) begin
            o     <= make_rsp(n_big ? n : '0, n_big, '0, 1'b0, 1'b1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.factor       = o.factor;
  assign rsp.factor_valid = o.factor_valid;
  assign rsp.prime_count  = o.prime_count;
  assign rsp.not_ready    = o.not_ready;
  assign rsp.last         = o.last;

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst)
    sqrt_start |-> !sqrt_busy)
    else $error("root unit started while busy");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item taken while one is in work");

  a_nr_only_unbuilt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o.not_ready) |-> !table_ready)
    else $error("not-ready result with a built table");

endmodule

// ===== design/stdf_ram.sv =====
module stdf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/stdf_div.sv =====
module stdf_div import stdf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   dividend,
  input  logic [PRIME_W-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [NUM_W-1:0]   quot,
  output logic [PRIME_W-1:0] rem
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]   quo;
  logic [PRIME_W-1:0] rmd;
  logic [STEP_W-1:0]  step;
  logic [PRIME_W:0]   trial;
  logic [PRIME_W:0]   diff;
  logic               fits;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rmd, quo[NUM_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rmd  <= '0;
        step <= STEP_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rmd <= diff[PRIME_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rmd <= trial[PRIME_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = quo;
  assign rem  = rmd;

endmodule

// ===== design/stdf_sqrt.sv =====
module stdf_sqrt import stdf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  n,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int SW     = NUM_W + 1;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [SW-1:0]     rn;
  logic [SW-1:0]     res;
  logic [SW-1:0]     bitv;
  logic [SW-1:0]     sum;
  logic [STEP_W-1:0] step;
  logic              ge;

  // digit-by-digit square root, one result bit a cycle
  always_comb begin
    sum = res + bitv;
    ge  = rn >= sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rn   <= {1'b0, n};
        res  <= '0;
        bitv <= SW'(1) << (2 * (ROOT_W - 1));
        step <= STEP_W'(ROOT_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rn  <= rn - sum;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[ROOT_W-1:0];

endmodule

// ===== dv/tb.sv =====
module tb;
  import stdf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    action_t          act;
    logic [NUM_W-1:0] num;
  } job_t;

  // idle phases: none, sender idle, receiver stall, both
  localparam int PHASES = 4;

  logic clk;
  logic rst;

  stdf_req_if req_if ();
  stdf_rsp_if rsp_if ();

  sieve_trial_division_factorizer u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  job_t jobs_pending[$];
  rsp_t results_due[$];
  int   n_jobs;
  int   n_sent;
  int   n_errors;

  // own copy of the prime table and state
  int   table_primes[$];
  bit   built;
  int   stored_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000ms;
    $display("tb: done, errors");
    $finish;
  end

  task automatic report(string what, rsp_t got);
    n_errors++;
    $display("tb: mismatch %s: factor=%0d fv=%0b cnt=%0d nr=%0b last=%0b at %0t", what,
             got.factor, got.factor_valid, got.prime_count, got.not_ready, got.last, $time);
  endtask

  function automatic void add_due(rsp_t r);
    results_due.insert(results_due.size(), r);
  endfunction

  // table of primes up to SIEVE_LIMIT, capped at PRIME_SLOTS
  function automatic void sieve_primes();
    bit composite[];
    composite = new[SIEVE_LIMIT + 1];
    table_primes.delete();
    for (int i = 2; i <= SIEVE_LIMIT; i++) begin
      if (!composite[i]) begin
        if (table_primes.size() < PRIME_SLOTS) table_primes.insert(table_primes.size(), i);
        for (longint j = longint'(i) * i; j <= SIEVE_LIMIT; j += i) composite[j] = 1'b1;
      end
    end
  endfunction

  function automatic int floor_root(longint n);
    longint r;
    r = longint'($sqrt(real'(n)));
    while (r * r > n) r--;
    while ((r + 1) * (r + 1) <= n) r++;
    return int'(r);
  endfunction

  function automatic void predict_factors(action_t act, logic [NUM_W-1:0] num);
    longint rem;
    int root, bound, k;
    if (act == ACT_BUILD) begin
      sieve_primes();
      built = 1'b1;
      stored_count = table_primes.size();
      add_due(make_rsp('0, 1'b0, CNT_W'(stored_count), 1'b0, 1'b1));
      return;
    end
    if (!built) begin
      add_due(make_rsp('0, 1'b0, '0, 1'b1, 1'b1));
      return;
    end
    rem = num;
    if (rem <= 1) begin
      add_due(make_rsp('0, 1'b0, '0, 1'b0, 1'b1));
      return;
    end
    root = floor_root(rem);
    bound = 0;
    while (bound < stored_count && table_primes[bound] < root) bound++;
    if (bound >= stored_count) bound = stored_count - 1;
    k = 0;
    for (int i = 0; i <= bound; i++) begin
      while (rem % table_primes[i] == 0 && k < 31) begin
        add_due(make_rsp(NUM_W'(table_primes[i]), 1'b1, '0, 1'b0, 1'b0));
        rem = rem / table_primes[i];
        k++;
      end
    end
    if (rem > 1 && k < 31) begin
      add_due(make_rsp(NUM_W'(rem), 1'b1, '0, 1'b0, 1'b0));
      k++;
    end
    // final result of the item carries last
    results_due[$].last = 1'b1;
  endfunction

  function automatic int phase_now();
    return (n_sent * PHASES) / (n_jobs + 1);
  endfunction

  // driver: next transfer goes out once the current one is taken
  always @(posedge clk) begin
    int ph;
    bit hold;
    ph = phase_now();
    hold = (ph == 1) ? ($urandom_range(99) < 83) :
           (ph == 3) ? ($urandom_range(99) < 26) : 1'b0;
    if (rst) begin
      req_if.valid  <= 1'b0;
      req_if.action <= ACT_BUILD;
      req_if.number <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (jobs_pending.size() > 0 && !hold) begin
        job_t j;
        j = jobs_pending.pop_front();
        req_if.valid  <= 1'b1;
        req_if.action <= j.act;
        req_if.number <= j.num;
        n_sent++;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // accepted request transfers feed the predictor
  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready) predict_factors(req_if.action, req_if.number);
  end

  // receiver back-pressure, per phase
  always @(posedge clk) begin
    int ph;
    ph = phase_now();
    if (rst) rsp_if.ready <= 1'b0;
    else if (ph == 2) rsp_if.ready <= ($urandom_range(99) >= 83);
    else if (ph == 3) rsp_if.ready <= ($urandom_range(99) >= 26);
    else rsp_if.ready <= 1'b1;
  end

  // monitor: each response transfer against the oldest expectation
  always @(posedge clk) begin
    rsp_t got, want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.factor       = rsp_if.factor;
      got.factor_valid = rsp_if.factor_valid;
      got.prime_count  = rsp_if.prime_count;
      got.not_ready    = rsp_if.not_ready;
      got.last         = rsp_if.last;
      if (results_due.size() == 0) begin
        report("unexpected result", got);
      end else begin
        want = results_due.pop_front();
        if (got.factor !== want.factor) report("factor", got);
        if (got.factor_valid !== want.factor_valid) report("factor_valid", got);
        if (got.prime_count !== want.prime_count) report("prime_count", got);
        if (got.not_ready !== want.not_ready) report("not_ready", got);
        if (got.last !== want.last) report("last", got);
      end
    end
  end

  task automatic add_job(action_t act, longint num);
    job_t j;
    j.act = act;
    j.num = NUM_W'(num);
    jobs_pending.insert(jobs_pending.size(), j);
  endtask

  function automatic longint table_pick();
    int small_primes[10] = '{2, 3, 5, 7, 11, 13, 101, 251, 1009, 4093};
    return small_primes[$urandom_range(9)];
  endfunction

  initial begin
    longint v;
    rst = 1'b1;
    n_sent = 0;
    n_errors = 0;
    built = 1'b0;
    stored_count = 0;
    req_if.valid = 1'b0;
    req_if.action = ACT_BUILD;
    req_if.number = '0;
    rsp_if.ready = 1'b0;

    // directed: factoring before any build, then the build
    add_job(ACT_FACTOR, 12);
    add_job(ACT_BUILD, 31'h5555_5555);
    add_job(ACT_FACTOR, 0);                 // zero behaves like one
    add_job(ACT_FACTOR, 1);
    add_job(ACT_FACTOR, 2);
    add_job(ACT_FACTOR, 3);
    add_job(ACT_FACTOR, 4);
    add_job(ACT_FACTOR, 64'd1 << 30);       // thirty factors of two
    add_job(ACT_FACTOR, 2147483647);        // large prime, table scanned up to its root
    add_job(ACT_FACTOR, 2147483646);
    add_job(ACT_FACTOR, 2147117569);        // square of a prime, root hits it exactly
    add_job(ACT_FACTOR, 64'd46327 * 46337);
    add_job(ACT_FACTOR, 65536);
    add_job(ACT_FACTOR, 65537);             // prime just past the sieve range
    add_job(ACT_FACTOR, 64'd999983 * 2);
    add_job(ACT_FACTOR, 64'd3 * 5 * 7 * 11 * 13 * 17 * 19 * 23);
    add_job(ACT_FACTOR, 31'h2aaa_aaaa);

    // random: mostly small numbers keep trial division short
    for (int i = 0; i < 84; i++) begin
      case ($urandom_range(9))
        0: v = $urandom_range(2147483647, 1);
        1, 2: begin
          v = 1;
          repeat ($urandom_range(8, 1)) v = v * table_pick();
        end
        default: v = $urandom_range(1 << 20, 0);
      endcase
      if (v > 2147483647) v = $urandom_range(1 << 20, 2);
      add_job(ACT_FACTOR, v);
    end
    n_jobs = jobs_pending.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (jobs_pending.size() != 0 || req_if.valid || results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (200) @(posedge clk);
    if (n_errors == 0 && results_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/stdf_pkg.sv
design/stdf_req_if.sv
design/stdf_rsp_if.sv
design/stdf_ram.sv
design/stdf_div.sv
design/stdf_sqrt.sv
design/sieve_trial_division_factorizer.sv
dv/tb.sv
